// File: rtl/htc_pkg.sv
package htc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam int IN_W      = FRAC_BITS + 2;   // signed Q2.F sample
   localparam int CFG_W     = FRAC_BITS + 1;   // Q1.F thresholds
   localparam int V_W       = FRAC_BITS + 1;   // clamped height 0..ONE
   localparam int Q_W       = 8;               // ramp factor, at most 236
   localparam int NUM_W     = V_W + Q_W;       // d * span
   localparam int LANES     = 3;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

   localparam logic [V_W-1:0] ONE_V     = V_W'(ONE_Q);
   localparam logic [V_W-1:0] MIN_RANGE = V_W'(ONE_Q / 10000);

   // CSR register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WATER_LEVEL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNTAIN_LEVEL = 2'd1;
   localparam logic [CFG_W-1:0] WATER_LEVEL_RST    = CFG_W'(19661);
   localparam logic [CFG_W-1:0] MOUNTAIN_LEVEL_RST = CFG_W'(45875);

   // lane order
   localparam logic [1:0] LANE_RED   = 2'd0;
   localparam logic [1:0] LANE_GREEN = 2'd1;
   localparam logic [1:0] LANE_BLUE  = 2'd2;

   // colors
   localparam logic [7:0] WATER_R = 8'd0;
   localparam logic [7:0] WATER_G = 8'd105;
   localparam logic [7:0] WATER_B = 8'd148;
   localparam logic [7:0] LAND_R  = 8'd34;
   localparam logic [7:0] LAND_G  = 8'd139;
   localparam logic [7:0] LAND_B  = 8'd34;
   localparam logic [7:0] MOUNT_R = 8'd139;
   localparam logic [7:0] MOUNT_G = 8'd69;
   localparam logic [7:0] MOUNT_B = 8'd19;
   localparam logic [7:0] WHITE   = 8'd255;
   localparam logic [7:0] LAND_SPAN = 8'd20;

   typedef enum logic [1:0] {
      ZONE_WATER,
      ZONE_LAND,
      ZONE_MOUNT
   } zone_type;

   typedef struct packed {
      logic     valid;
      zone_type zone;
   } tag_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [Q_W-1:0]   quo;
   } lane_type;

   // one word of the divider pipe; divisor is pre-shifted, halves per step
   typedef struct packed {
      tag_type                tag;
      logic [NUM_W-1:0]       divisor;
      lane_type [LANES-1:0]   lane;
   } div_word_type;

   function automatic logic [Q_W-1:0] lane_span(logic [1:0] lane, zone_type zone);
      logic [Q_W-1:0] span;
      span = '0;
      case (zone)
         ZONE_LAND: begin
            if (lane != LANE_BLUE) span = LAND_SPAN;
         end
         ZONE_MOUNT: begin
            case (lane)
               LANE_RED:   span = WHITE - MOUNT_R;
               LANE_GREEN: span = WHITE - MOUNT_G;
               LANE_BLUE:  span = WHITE - MOUNT_B;
               default:    span = '0;
            endcase
         end
         default: span = '0;
      endcase
      return span;
   endfunction

endpackage

// File: rtl/htc_classify.sv
module htc_classify
   import htc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [IN_W-1:0]    height,
   input  logic [CFG_W-1:0]   water_level,
   input  logic [CFG_W-1:0]   mountain_level,
   output div_word_type       word_out
);

   // stage A: clamp, zone, offset and band width
   tag_type          a_tag_ff,   a_tag_in;
   logic [V_W-1:0]   a_d_ff,     a_d_in;
   logic [V_W-1:0]   a_range_ff, a_range_in;
   logic [V_W-1:0]   v;

   // stage B: products and pre-shifted divisor
   div_word_type     b_word_ff,  b_word_in;

   always_comb begin
      if (height[IN_W-1])
         v = '0;
      else if (V_W'(height[IN_W-2:0]) > ONE_V)
         v = ONE_V;
      else
         v = V_W'(height[IN_W-2:0]);

      a_tag_in.valid = in_valid;
      if (v < water_level) begin
         a_tag_in.zone = ZONE_WATER;
         a_d_in        = '0;
         a_range_in    = V_W'(1);
      end else if (v < mountain_level) begin
         a_tag_in.zone = ZONE_LAND;
         a_d_in        = v - water_level;
         a_range_in    = mountain_level - water_level;
      end else begin
         a_tag_in.zone = ZONE_MOUNT;
         a_d_in        = v - mountain_level;
         a_range_in    = ONE_V - mountain_level;
      end

      // narrow band: factor is zero
      if (a_range_in <= MIN_RANGE) begin
         a_d_in     = '0;
         a_range_in = V_W'(1);
      end
   end

   always_comb begin
      b_word_in.tag     = a_tag_ff;
      b_word_in.divisor = NUM_W'(a_range_ff) << (Q_W - 1);
      for (int l = 0; l < LANES; l++) begin
         b_word_in.lane[l].rem = NUM_W'(a_d_ff) * NUM_W'(lane_span(2'(l), a_tag_ff.zone));
         b_word_in.lane[l].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      a_d_ff     <= a_d_in;
      a_range_ff <= a_range_in;
      if (reset) begin
         a_tag_ff.valid       <= 1'b0;
         b_word_ff.tag.valid  <= 1'b0;
      end else begin
         a_tag_ff  <= a_tag_in;
         b_word_ff <= b_word_in;
      end
   end

   assign word_out = b_word_ff;

endmodule

// File: rtl/htc_div_stage.sv
module htc_div_stage
   import htc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_word_type  word_i,
   output div_word_type  word_o
);

   div_word_type word_ff, word_in;

   // restoring division, quotient bits MSB first
   always_comb begin
      word_in = word_i;
      for (int s = 0; s < BITS_PER_STAGE; s++) begin
         for (int l = 0; l < LANES; l++) begin
            if (word_in.lane[l].rem >= word_in.divisor) begin
               word_in.lane[l].rem = word_in.lane[l].rem - word_in.divisor;
               word_in.lane[l].quo = {word_in.lane[l].quo[Q_W-2:0], 1'b1};
            end else begin
               word_in.lane[l].quo = {word_in.lane[l].quo[Q_W-2:0], 1'b0};
            end
         end
         word_in.divisor = word_in.divisor >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) word_ff.tag.valid <= 1'b0;
      else       word_ff <= word_in;
   end

   assign word_o = word_ff;

endmodule

// File: rtl/height_to_terrain_color_unit.sv
// Height to terrain color: one signed Q2.16 height per item in, one RGB pixel
// per item out, one item per clock. Every item accepted with start gives
// exactly one pixel on rsp_red/rsp_green/rsp_blue, marked by rsp_valid for a
// single cycle; pixels leave in input order and the receiver cannot stall
// them. Each item passes a clamp/classify stage, a multiply stage, the ramp
// divider (an 8-bit quotient by restoring division, two bits per stage over 4
// stages) and the output register. busy is high only in reset. Thresholds are
// written through the csr_ port (index 0 water_level, index 1 mountain_level,
// other indexes ignored) and must only be changed while no item is in flight.
module height_to_terrain_color_unit
   import htc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  logic [IN_W-1:0]       req_height,

   output logic                  rsp_valid,
   output logic [7:0]            rsp_red,
   output logic [7:0]            rsp_green,
   output logic [7:0]            rsp_blue,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic               busy_ff;
   logic [CFG_W-1:0]   water_level_ff;
   logic [CFG_W-1:0]   mountain_level_ff;
   logic               accept;

   div_word_type       pipe [DIV_STAGES+1];

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_red_ff,   out_red_in;
   logic [7:0]         out_green_ff, out_green_in;
   logic [7:0]         out_blue_ff,  out_blue_in;
   div_word_type       last;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff           <= 1'b1;
         water_level_ff    <= WATER_LEVEL_RST;
         mountain_level_ff <= MOUNTAIN_LEVEL_RST;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WATER_LEVEL:    water_level_ff    <= csr_wdata;
               CSR_MOUNTAIN_LEVEL: mountain_level_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // clamp, classify and multiply (two stages)
   htc_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept),
      .height         (req_height),
      .water_level    (water_level_ff),
      .mountain_level (mountain_level_ff),
      .word_out       (pipe[0])
   );

   // divider stages: factor = d * span / range, truncated
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      htc_div_stage u_div (
         .clock  (clock),
         .reset  (reset),
         .word_i (pipe[i]),
         .word_o (pipe[i+1])
      );
   end

   assign last = pipe[DIV_STAGES];

   // add the band's base color
   always_comb begin
      out_valid_in = last.tag.valid;
      case (last.tag.zone)
         ZONE_LAND: begin
            out_red_in   = LAND_R + last.lane[LANE_RED].quo;
            out_green_in = LAND_G + last.lane[LANE_GREEN].quo;
            out_blue_in  = LAND_B;
         end
         ZONE_MOUNT: begin
            out_red_in   = MOUNT_R + last.lane[LANE_RED].quo;
            out_green_in = MOUNT_G + last.lane[LANE_GREEN].quo;
            out_blue_in  = MOUNT_B + last.lane[LANE_BLUE].quo;
         end
         default: begin
            out_red_in   = WATER_R;
            out_green_in = WATER_G;
            out_blue_in  = WATER_B;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_red_ff   <= out_red_in;
      out_green_ff <= out_green_in;
      out_blue_ff  <= out_blue_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = out_red_ff;
   assign rsp_green = out_green_ff;
   assign rsp_blue  = out_blue_ff;

endmodule

// File: tb/height_to_terrain_color_unit_tb.sv
`timescale 1ns / 100ps

module height_to_terrain_color_unit_tb;
   import htc_pkg::*;

   // ------------------------------------------------------------------
   // Constants of the color map, kept apart from the design's own copies
   // ------------------------------------------------------------------
   localparam int unsigned ONE_HT       = 65536;           // 1.0 in Q16
   localparam int unsigned NARROW_RANGE = ONE_HT / 10000;  // band too thin to ramp
   localparam logic [CFG_W-1:0] WATER_RST    = 17'd19661;
   localparam logic [CFG_W-1:0] MOUNTAIN_RST = 17'd45875;

   // indexes that decode to no register; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int NUM_PHASES   = 12;
   localparam int PHASE_ITEMS  = 152;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int TAIL_CYCLES  = 16;   // pipe is 7 deep, give it double
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // ------------------------------------------------------------------
   // DUT signals; every input known from time zero
   // ------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [IN_W-1:0]      req_height = '0;
   logic                 rsp_valid;
   logic [7:0]           rsp_red;
   logic [7:0]           rsp_green;
   logic [7:0]           rsp_blue;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   height_to_terrain_color_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_height (req_height),
      .rsp_valid  (rsp_valid),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   logic [IN_W-1:0] height_backlog[$];   // samples not yet taken by the block
   pixel_type       pending_pixels[$];   // pixels owed by the block, oldest first

   // thresholds as the block should hold them, tracked from csr handshakes
   logic [CFG_W-1:0] water_cfg    = WATER_RST;
   logic [CFG_W-1:0] mountain_cfg = MOUNTAIN_RST;

   logic req_fire    = 1'b0;   // item taken at the last rising edge
   logic draining    = 1'b0;   // sender holding off until the pipe is empty
   int   idle_pct    = 16;
   int   mismatches  = 0;
   int   samples_in  = 0;
   int   pixels_out  = 0;
   int   settings    = 1;
   int   drains      = 0;
   int   cycle_count = 0;

   // ------------------------------------------------------------------
   // Color map predictor
   // ------------------------------------------------------------------
   // base + d*span/rng, truncated; thin bands hold the base color
   function automatic int unsigned band_ramp(int unsigned base, int unsigned span,
                                             int unsigned d, int unsigned rng);
      if (rng <= NARROW_RANGE) return base;
      return base + (d * span) / rng;
   endfunction

   function automatic pixel_type terrain_pixel(logic [IN_W-1:0] raw);
      int unsigned v;
      int unsigned f;
      int unsigned rng;
      int unsigned d;
      pixel_type   px;
      // clamp to 0 .. 1.0: negatives to zero, anything above one to one
      if (raw[IN_W-1])
         v = 0;
      else if (raw > ONE_HT)
         v = ONE_HT;
      else
         v = 32'(raw);

      if (v < water_cfg) begin
         px = '{8'd0, 8'd105, 8'd148};
      end else if (v < mountain_cfg) begin
         // green band, same factor on red and green, blue flat
         f = band_ramp(0, 20, v - water_cfg, mountain_cfg - water_cfg);
         px.red   = 8'(34 + f);
         px.green = 8'(139 + f);
         px.blue  = 8'd34;
      end else begin
         // brown to white; v <= 1.0 here so mountain_cfg <= 1.0 as well
         rng = ONE_HT - mountain_cfg;
         d   = v - mountain_cfg;
         px.red   = 8'(band_ramp(139, 255 - 139, d, rng));
         px.green = 8'(band_ramp(69, 255 - 69, d, rng));
         px.blue  = 8'(band_ramp(19, 255 - 19, d, rng));
      end
      return px;
   endfunction

   // ------------------------------------------------------------------
   // Sample generator: aims at the band edges and the inside of each band
   // ------------------------------------------------------------------
   function automatic logic [IN_W-1:0] pick_height(int w, int m);
      int mode;
      int h;
      int edges[8];
      mode = $urandom_range(99);
      if (mode < 10)
         return {1'b1, 17'($urandom)};                  // negative, any magnitude
      if (mode < 18)
         return IN_W'($urandom_range(131071, ONE_HT + 1)); // above one
      if (mode < 32) begin
         edges = '{0, ONE_HT, w - 1, w, w + 1, m - 1, m, m + 1};
         h = edges[$urandom_range(7)];
      end else if (mode < 55 && m > w) begin
         h = $urandom_range(m - 1, w);                  // green band
      end else if (mode < 75 && m <= ONE_HT) begin
         h = $urandom_range(ONE_HT, m);                 // mountain band
      end else begin
         h = $urandom_range(ONE_HT, 0);
      end
      return IN_W'(h);
   endfunction

   // ------------------------------------------------------------------
   // Driver: presents the head of the backlog, changes on the falling edge.
   // The head stays queued until the monitor sees it taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      if (reset) begin
         start <= 1'b0;
         draining = 1'b0;
      end else begin
         // now and then stop feeding until every owed pixel is back
         if (!draining && idle_pct != 0 && pending_pixels.size() != 0
             && $urandom_range(149) == 0) begin
            draining = 1'b1;
            drains++;
         end
         if (draining && pending_pixels.size() == 0)
            draining = 1'b0;

         if (!start || req_fire) begin
            if (height_backlog.size() != 0 && !draining
                && $urandom_range(99) >= idle_pct) begin
               start      <= 1'b1;
               req_height <= height_backlog[0];
            end else begin
               start      <= 1'b0;
               req_height <= IN_W'($urandom);   // junk while idle
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: everything sampled on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      pixel_type seen;
      pixel_type want;
      if (reset) begin
         water_cfg    = WATER_RST;
         mountain_cfg = MOUNTAIN_RST;
         req_fire     = 1'b0;
      end else begin
         // result side: one pixel per strobe, in order
         if (rsp_valid) begin
            seen = '{rsp_red, rsp_green, rsp_blue};
            pixels_out++;
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: pixel (%0d,%0d,%0d) with none owed", $realtime,
                           seen.red, seen.green, seen.blue);
            end else begin
               want = pending_pixels.pop_front();
               if (seen.red !== want.red || seen.green !== want.green
                   || seen.blue !== want.blue) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: pixel mismatch exp (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                              $realtime, want.red, want.green, want.blue,
                              seen.red, seen.green, seen.blue);
               end
            end
         end

         // request side: predict with thresholds in force at acceptance
         req_fire = start && !busy;
         if (req_fire) begin
            pending_pixels.push_back(terrain_pixel(req_height));
            if (height_backlog.size() != 0) void'(height_backlog.pop_front());
            samples_in++;
         end

         // csr side; unused indexes change nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WATER_LEVEL:    water_cfg    = csr_wdata;
               CSR_MOUNTAIN_LEVEL: mountain_cfg = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------
   task automatic write_threshold(input logic [CSR_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // every sample taken and every pixel back; checked off the rising edge
   task automatic wait_idle();
      while (height_backlog.size() != 0 || pending_pixels.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int ph;
      int w;
      int m;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass on reset thresholds (19661 / 45875): clamp extremes,
      // both band edges, top of range giving pure white
      height_backlog.push_back(IN_W'(-131072));
      height_backlog.push_back(IN_W'(-1));
      height_backlog.push_back(IN_W'(0));
      height_backlog.push_back(IN_W'(1));
      height_backlog.push_back(IN_W'(19660));
      height_backlog.push_back(IN_W'(19661));
      height_backlog.push_back(IN_W'(19662));
      height_backlog.push_back(IN_W'(32768));
      height_backlog.push_back(IN_W'(45874));
      height_backlog.push_back(IN_W'(45875));
      height_backlog.push_back(IN_W'(45876));
      height_backlog.push_back(IN_W'(65535));
      height_backlog.push_back(IN_W'(65536));
      height_backlog.push_back(IN_W'(65537));
      height_backlog.push_back(IN_W'(98304));
      height_backlog.push_back(IN_W'(131071));

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         case (ph)
            0:  begin w = 0;      m = ONE_HT;      end // green all the way up
            1:  begin w = 40000;  m = 20000;       end // crossed, no green band
            2:  begin w = 0;      m = 0;           end // all mountain
            3:  begin w = 131071; m = 131071;      end // all water, max code
            4:  begin w = 10000;  m = 10006;       end // green band too thin
            5:  begin w = 10000;  m = 10007;       end // just wide enough
            6:  begin w = 30000;  m = ONE_HT - 6;  end // mountain band too thin
            7:  begin w = 30000;  m = ONE_HT - 7;  end
            8:  begin w = 0;      m = 131071;      end // mountain out of reach
            10: begin
               w = $urandom_range(131071, 0);
               m = $urandom_range(131071, 0);
            end
            default: begin
               w = $urandom_range(ONE_HT, 0);
               m = $urandom_range(ONE_HT, w);
            end
         endcase
         write_threshold(CSR_WATER_LEVEL, CFG_W'(w));
         write_threshold(CSR_MOUNTAIN_LEVEL, CFG_W'(m));
         if (ph == 3 || ph == 10) begin
            write_threshold(CSR_SPARE_2, CFG_W'($urandom));
            write_threshold(CSR_SPARE_3, CFG_W'($urandom));
         end
         settings++;

         // one phase streams back to back with no gaps at all
         idle_pct = (ph == 9) ? 0 : 16;

         @(posedge clock);
         repeat (PHASE_ITEMS) height_backlog.push_back(pick_height(w, m));
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d height samples through %0d threshold settings, %0d pixels checked,",
               samples_in, settings, pixels_out);
      $display("incl. crossed, thin, above-one and unused-index writes; %0d mid-run drains.",
               drains);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d pixels never seen", mismatches,
                  pending_pixels.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
